@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL, used by the unpacker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed: invariant");

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/mbu_pkg.sv @@
package mbu_pkg;

	localparam int STORE_BITS = 64;
	localparam int CNT_W = 7;
	localparam int VALUE_W = 64;
	localparam int BYTE_W = 8;
	localparam int FILL_LIMIT = STORE_BITS - BYTE_W;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_READ = 2'd1,
		CMD_SKIP = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [BYTE_W-1:0]  data_byte;
		logic [CNT_W-1:0]   read_width;
	} cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		status_t            status;
		logic [CNT_W-1:0]   bits_held;
	} res_t;

endpackage

@@ hw/rtl/mbu_front.sv @@
module mbu_front import mbu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              op,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [CNT_W-1:0]  read_width,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_take
);

	cmd_t       cmd_in;
	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;

	// A read of zero bits touches no state, so it is tagged here and skipped later.
	always_comb begin
		cmd_in.data_byte  = data_byte;
		cmd_in.read_width = read_width;
		if (op == OP_PUSH) begin
			cmd_in.kind = CMD_PUSH;
		end else if (read_width == '0) begin
			cmd_in.kind = CMD_SKIP;
		end else begin
			cmd_in.kind = CMD_READ;
		end
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/mbu_back.sv @@
module mbu_back import mbu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_take,
	output logic             empty,
	input  logic             pop,
	output res_t             res,
	output logic [CNT_W-1:0] held_count
);

	logic [STORE_BITS-1:0] store_q;
	logic [CNT_W-1:0]      held_q;
	logic [STORE_BITS-1:0] store_d;
	logic [CNT_W-1:0]      held_d;
	logic [STORE_BITS-1:0] byte_ext;
	logic [CNT_W-1:0]      room_shift;
	logic [CNT_W-1:0]      take_shift;
	res_t                  res_d;
	res_t                  slot_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  exec;
	logic                  rd_en;

	assign cmd_take   = (count_q != 2'd2);
	assign exec       = cmd_valid && cmd_take;
	assign empty      = (count_q == 2'd0);
	assign rd_en      = pop && !empty;
	assign res        = slot_q[rd_ptr_q];
	assign held_count = held_q;

	assign byte_ext   = STORE_BITS'(cmd.data_byte);
	assign room_shift = CNT_W'(FILL_LIMIT) - held_q;
	assign take_shift = CNT_W'(STORE_BITS) - cmd.read_width;

	// Held bits sit at the top of the store; free bits below them stay zero.
	always_comb begin
		store_d          = store_q;
		held_d           = held_q;
		res_d.read_value = '0;
		res_d.status     = STAT_OK;
		unique case (cmd.kind)
			CMD_PUSH: begin
				if (held_q > CNT_W'(FILL_LIMIT)) begin
					res_d.status = STAT_FULL;
				end else begin
					store_d = store_q | (byte_ext << room_shift);
					held_d  = held_q + CNT_W'(BYTE_W);
				end
			end
			CMD_READ: begin
				if (cmd.read_width > held_q) begin
					res_d.status = STAT_SHORT;
				end else begin
					res_d.read_value = VALUE_W'(store_q >> take_shift);
					store_d          = store_q << cmd.read_width;
					held_d           = held_q - cmd.read_width;
				end
			end
			default: begin
			end
		endcase
		res_d.bits_held = held_d;
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			slot_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q  <= '0;
			held_q   <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (exec) begin
				store_q  <= store_d;
				held_q   <= held_d;
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({exec, rd_en})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/msb_first_bit_unpacker_unit.sv @@
// MSB-first bit unpacker with a 64-bit buffer. Each push appends one byte after the held
// bits, and each read returns the oldest 1 to 64 bits right-aligned; every transaction
// yields exactly one result carrying a status and the count of bits held afterward. The
// unit sustains one transaction per clock while no queue is full: the buffer shifter and
// count update in the back end handle one item per cycle, and a two-entry queue on each
// side lets either side stall alone. Each item is queued as a command, then as a result.
`include "assert_macros.svh"

module msb_first_bit_unpacker_unit import mbu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               op,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic [CNT_W-1:0]   read_width,
	output logic               empty,
	input  logic               pop,
	output logic [VALUE_W-1:0] read_value,
	output logic [1:0]         status,
	output logic [CNT_W-1:0]   bits_held
);

	logic             cmd_valid;
	logic             cmd_take;
	cmd_t             cmd;
	res_t             res;
	logic [CNT_W-1:0] held_count;

	mbu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.data_byte  (data_byte),
		.read_width (read_width),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	mbu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take),
		.empty      (empty),
		.pop        (pop),
		.res        (res),
		.held_count (held_count)
	);

	assign read_value = res.read_value;
	assign status     = res.status;
	assign bits_held  = res.bits_held;

	`ASSERT_ALWAYS(a_held_in_range, clk, arst_n, held_count <= CNT_W'(STORE_BITS))
	`ASSERT_NEXT(a_accept_queues_cmd, clk, arst_n, push && !full, cmd_valid)
	`ASSERT_ALWAYS(a_fail_has_no_value, clk, arst_n, empty || status == STAT_OK || read_value == '0)
	`ASSERT_ALWAYS(a_status_legal, clk, arst_n, empty || status != 2'd3)

endmodule

@@ test/tb_top.sv @@
module tb_top;
	import mbu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic              op;
		logic [BYTE_W-1:0] data_byte;
		logic [CNT_W-1:0]  read_width;
	} bit_req_t;

	typedef struct {
		logic [VALUE_W-1:0] read_value;
		status_t            status;
		logic [CNT_W-1:0]   bits_held;
	} bit_rsp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic               op = OP_PUSH;
	logic [BYTE_W-1:0]  data_byte = '0;
	logic [CNT_W-1:0]   read_width = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [VALUE_W-1:0] read_value;
	logic [1:0]         status;
	logic [CNT_W-1:0]   bits_held;

	bit_req_t pending_reqs[$];
	bit_rsp_t expected_rsps[$];

	// Predictor state: the bit buffer and its fill level.
	logic [STORE_BITS-1:0] bit_buf = '0;
	int                    held_bits = 0;

	// Fill level as the stimulus generator sees it, used to shape sequences.
	int gen_held = 0;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_reqs = 0;
	int  holds_done = 0;
	int  hold_left = 0;
	int  mismatches = 0;
	int  cycles = 0;
	logic in_taken = 1'b0;

	msb_first_bit_unpacker_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.data_byte  (data_byte),
		.read_width (read_width),
		.empty      (empty),
		.pop        (pop),
		.read_value (read_value),
		.status     (status),
		.bits_held  (bits_held)
	);

	always #1 clk = ~clk;

	function automatic bit_rsp_t unpack_step(bit_req_t req);
		bit_rsp_t rsp;
		int       n;
		rsp.read_value = '0;
		rsp.status = STAT_OK;
		n = int'(req.read_width);
		if (req.op == OP_PUSH) begin
			if (held_bits > FILL_LIMIT) begin
				rsp.status = STAT_FULL;
			end else begin
				bit_buf = bit_buf | (STORE_BITS'(req.data_byte) << (FILL_LIMIT - held_bits));
				held_bits += BYTE_W;
			end
		end else if (n > held_bits) begin
			rsp.status = STAT_SHORT;
		end else if (n != 0) begin
			rsp.read_value = VALUE_W'(bit_buf >> (STORE_BITS - n));
			// A shift by the full width clears the buffer.
			bit_buf = bit_buf << n;
			held_bits -= n;
		end
		rsp.bits_held = CNT_W'(held_bits);
		return rsp;
	endfunction

	function automatic void add_item(logic o, logic [BYTE_W-1:0] d, logic [CNT_W-1:0] w);
		bit_req_t req;
		req.op = o;
		req.data_byte = d;
		req.read_width = w;
		pending_reqs.push_back(req);
		if (o == OP_PUSH) begin
			if (gen_held <= FILL_LIMIT)
				gen_held += BYTE_W;
		end else if (w != 0 && int'(w) <= gen_held) begin
			gen_held -= int'(w);
		end
	endfunction

	// Mostly well-formed traffic that keeps the buffer moving, with some noise.
	function automatic void add_random_item();
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			add_item(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
				CNT_W'($urandom_range(127)));
		end else if (gen_held < BYTE_W || (gen_held <= FILL_LIMIT && $urandom_range(1) == 1)) begin
			add_item(OP_PUSH, BYTE_W'($urandom_range(255)), CNT_W'($urandom_range(127)));
		end else if ($urandom_range(3) == 0) begin
			add_item(OP_READ, BYTE_W'($urandom_range(255)), CNT_W'(gen_held));
		end else begin
			add_item(OP_READ, BYTE_W'($urandom_range(255)), CNT_W'($urandom_range(gen_held, 1)));
		end
	endfunction

	// Returns just after a rising edge, once nothing is pending or outstanding.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || push || expected_rsps.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_phase(int n_items, int s_pct, int r_pct, bit long_hold);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		if (long_hold)
			hold_reqs++;
		repeat (n_items)
			add_random_item();
		wait_drained();
	endtask

	// Sender side.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			expected_rsps.push_back(unpack_step(pending_reqs[0]));
			void'(pending_reqs.pop_front());
			in_taken <= 1'b1;
		end else begin
			in_taken <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!push || in_taken) begin
			if (arst_n && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				op <= pending_reqs[0].op;
				data_byte <= pending_reqs[0].data_byte;
				read_width <= pending_reqs[0].read_width;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver side, with a long hold-off counted here.
	always @(negedge clk) begin
		if (hold_reqs != holds_done) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		bit_rsp_t exp_rsp;
		if (arst_n && pop && !empty) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: read_value %h status %0d bits_held %0d",
						read_value, status, bits_held);
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (read_value !== exp_rsp.read_value || status !== exp_rsp.status
					|| bits_held !== exp_rsp.bits_held) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: read_value exp %h got %h,",
							exp_rsp.read_value, read_value,
							" status exp %0d got %0d,", exp_rsp.status, status,
							" bits_held exp %0d got %0d", exp_rsp.bits_held, bits_held);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Empty buffer: short read and zero-width read, then two pushes and reads of 1, 7 and 8 bits.
		add_item(OP_READ, 8'h00, 7'd1);
		add_item(OP_READ, 8'hFF, 7'd0);
		add_item(OP_PUSH, 8'hFF, 7'd0);
		add_item(OP_PUSH, 8'h00, 7'd127);
		add_item(OP_READ, 8'h00, 7'd1);
		add_item(OP_READ, 8'h00, 7'd7);
		add_item(OP_READ, 8'h00, 7'd8);
		// Fill all 64 bits, then try one byte more.
		add_item(OP_PUSH, 8'h80, 7'd64);
		add_item(OP_PUSH, 8'hA5, 7'd0);
		add_item(OP_PUSH, 8'h5A, 7'd0);
		add_item(OP_PUSH, 8'h01, 7'd0);
		add_item(OP_PUSH, 8'hFE, 7'd0);
		add_item(OP_PUSH, 8'h3C, 7'd0);
		add_item(OP_PUSH, 8'hC3, 7'd0);
		add_item(OP_PUSH, 8'h7E, 7'd0);
		add_item(OP_PUSH, 8'hFF, 7'd0);
		// Widths above the full buffer fail, then take everything at once, then a short read and a 16-bit read.
		add_item(OP_READ, 8'h00, 7'd65);
		add_item(OP_READ, 8'h00, 7'd127);
		add_item(OP_READ, 8'h00, 7'd0);
		add_item(OP_READ, 8'h00, 7'd64);
		add_item(OP_READ, 8'h00, 7'd1);
		add_item(OP_PUSH, 8'h12, 7'd0);
		add_item(OP_PUSH, 8'h34, 7'd0);
		add_item(OP_READ, 8'hFF, 7'd16);
		wait_drained();

		run_phase(275, 33, 80, 1'b0);
		run_phase(275, 80, 33, 1'b0);
		run_phase(275, 0, 0, 1'b1);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mbu_pkg.sv
hw/rtl/mbu_front.sv
hw/rtl/mbu_back.sv
hw/rtl/msb_first_bit_unpacker_unit.sv
test/tb_top.sv
